[src/stt_pkg.sv]
package stt_pkg;

    localparam int SLOTS    = 32;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int PERIOD_W = 32;
    localparam int TIME_W   = 64;
    localparam int MS_W     = 10;
    localparam int ID_W     = 6;

    localparam logic [MS_W-1:0] MS_PER_TICK_RESET = 10'd1;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [PERIOD_W-1:0] delay_ms;
        logic                repeating;
    } stt_in_t;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] slot_id;
        logic            last;
    } stt_out_t;

    // one table entry as held in the slot RAM
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   deadline;
        logic                rep;
    } stt_entry_t;

    localparam int ENTRY_W = $bits(stt_entry_t);

    // slot id is slot index plus one, kept to the id field width
    function automatic logic [ID_W-1:0] slot_id_of(input logic [CNT_W-1:0] n);
        logic [ID_W+CNT_W:0] tmp;
        tmp = {{(ID_W + 1){1'b0}}, n} + 1'b1;
        return tmp[ID_W-1:0];
    endfunction

endpackage

[src/stt_ram.sv]
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/stt_out_stage.sv]
module stt_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stt_pkg::stt_out_t push_data,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output stt_pkg::stt_out_t out_data
);

    logic              valid_reg;
    stt_pkg::stt_out_t data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

endmodule

[src/software_timer_table_core.sv]
// Software timer table.
// in channel (in_valid/in_ready/in_data): one command per transaction.
//   cmd register: takes the next free slot, deadline = now + delay_ms,
//   answers one result (kind 0, slot id or 0 when full, last 1).
//   cmd tick: now += ms_per_tick, then every used slot is scanned in
//   ascending order; each enabled slot with deadline <= now fires (kind 1).
//   Periodic slots are rescheduled to now + interval, one-shots disabled.
//   The final fired result of a tick carries last; no result if none fired.
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes ms_per_tick, always
//   ready; write only while the block is idle.
// A tick scans every used slot and then ends, with a flush step when a slot
// fired: the slot RAM is read one entry per cycle unless the scan stalls,
// and the read-modify-write of entry i overlaps the read of i+1. One fired
// result is held back until the next one (or the scan end) is known, so the
// last flag is exact. Stalls: a new hit while a result is held and the
// output register is full halts the scan in place; nothing is dropped.
// Inputs are taken only between commands.
// Reset: clock and used count cleared, all slots disabled, ms_per_tick = 1;
// no clearing pass, the block is ready right after reset.
module software_timer_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  stt_pkg::stt_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output stt_pkg::stt_out_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [stt_pkg::MS_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } state_t;

    state_t                          state_reg, state_next;
    logic [stt_pkg::MS_W-1:0]        ms_per_tick_reg;
    logic [stt_pkg::TIME_W-1:0]      now_ms_reg, now_ms_next;
    logic [stt_pkg::CNT_W-1:0]       used_reg, used_next;
    logic [stt_pkg::SLOTS-1:0]       enable_reg, enable_next;
    logic [stt_pkg::CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                            s1_valid_reg, s1_valid_next;
    logic [stt_pkg::IDX_W-1:0]       s1_idx_reg, s1_idx_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic                            pend_kind_reg, pend_kind_next;
    logic [stt_pkg::ID_W-1:0]        pend_id_reg, pend_id_next;

    // slot RAM ports
    logic                            ram_we;
    logic [stt_pkg::IDX_W-1:0]       ram_wr_addr;
    stt_pkg::stt_entry_t             ram_wr_entry;
    logic                            ram_re;
    logic [stt_pkg::IDX_W-1:0]       ram_rd_addr;
    logic [stt_pkg::ENTRY_W-1:0]     ram_rd_data;
    stt_pkg::stt_entry_t             rd_entry;

    logic                            out_free;
    logic                            push;
    stt_pkg::stt_out_t               push_data;
    logic                            hit;
    logic                            stall;

    stt_ram #(
        .WIDTH (stt_pkg::ENTRY_W),
        .DEPTH (stt_pkg::SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .re      (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    stt_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign rd_entry  = stt_pkg::stt_entry_t'(ram_rd_data);
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // entry in stage 1 is due: enabled and deadline reached
    assign hit   = s1_valid_reg && enable_reg[s1_idx_reg]
                   && (now_ms_reg >= rd_entry.deadline);
    // a second fired result cannot move the held one out yet
    assign stall = hit && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        now_ms_next     = now_ms_reg;
        used_next       = used_reg;
        enable_next     = enable_reg;
        rd_idx_next     = rd_idx_reg;
        s1_valid_next   = s1_valid_reg;
        s1_idx_next     = s1_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;

        ram_we       = 1'b0;
        ram_wr_addr  = s1_idx_reg;
        ram_wr_entry = rd_entry;
        ram_wr_entry.deadline = now_ms_reg + stt_pkg::TIME_W'(rd_entry.period);
        ram_re       = 1'b0;
        ram_rd_addr  = rd_idx_reg[stt_pkg::IDX_W-1:0];

        push              = 1'b0;
        push_data.kind    = pend_kind_reg;
        push_data.slot_id = pend_id_reg;
        push_data.last    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.cmd == stt_pkg::CMD_TICK)
                    begin
                        now_ms_next   = now_ms_reg + stt_pkg::TIME_W'(ms_per_tick_reg);
                        rd_idx_next   = '0;
                        s1_valid_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_kind_next  = stt_pkg::KIND_ANSWER;
                        pend_id_next    = '0;
                        if (used_reg < stt_pkg::CNT_W'(stt_pkg::SLOTS))
                        begin
                            ram_we                = 1'b1;
                            ram_wr_addr           = used_reg[stt_pkg::IDX_W-1:0];
                            ram_wr_entry.period   = in_data.delay_ms;
                            ram_wr_entry.deadline = now_ms_reg
                                                    + stt_pkg::TIME_W'(in_data.delay_ms);
                            ram_wr_entry.rep      = in_data.repeating;
                            enable_next[used_reg[stt_pkg::IDX_W-1:0]] = 1'b1;
                            used_next             = used_reg + stt_pkg::CNT_W'(1);
                            pend_id_next          = stt_pkg::slot_id_of(used_reg);
                        end
                        state_next = S_FLUSH;
                    end
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        // older fired result is not the last one
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_kind_next  = stt_pkg::KIND_FIRED;
                        pend_id_next    = stt_pkg::slot_id_of(stt_pkg::CNT_W'(s1_idx_reg));
                        if (rd_entry.rep)
                        begin
                            ram_we = 1'b1;
                        end
                        else
                        begin
                            enable_next[s1_idx_reg] = 1'b0;
                        end
                    end
                    if (rd_idx_reg < used_reg)
                    begin
                        ram_re        = 1'b1;
                        s1_valid_next = 1'b1;
                        s1_idx_next   = rd_idx_reg[stt_pkg::IDX_W-1:0];
                        rd_idx_next   = rd_idx_reg + stt_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        s1_valid_next = 1'b0;
                        state_next    = pend_valid_next ? S_FLUSH : S_IDLE;
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ms_per_tick_reg <= stt_pkg::MS_PER_TICK_RESET;
            now_ms_reg      <= '0;
            used_reg        <= '0;
            enable_reg      <= '0;
            rd_idx_reg      <= '0;
            s1_valid_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_ms_reg     <= now_ms_next;
            used_reg       <= used_next;
            enable_reg     <= enable_next;
            rd_idx_reg     <= rd_idx_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                ms_per_tick_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg    <= s1_idx_next;
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
    end

    // write-back never hits the entry being fetched in the same cycle
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_wr_addr != ram_rd_addr))
        else $error("slot RAM write and read target the same entry");

    // a result only moves into the output register when it has room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= stt_pkg::CNT_W'(stt_pkg::SLOTS))
        else $error("used count beyond table size");

    // no held result is left behind once back at idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result still pending at idle");

    // a stalled scan holds its fetch position
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && stall) |=> $stable(rd_idx_reg) && s1_valid_reg)
        else $error("scan moved during a stall");

endmodule
